// File: src/bpqel_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bounded priority queue.
// No dependencies; imported by bpqel_cell and the top level.
package bpqel_pkg;

	localparam int DEPTH   = 16;
	localparam int PRIO_W  = 8;
	localparam int PAY_W   = 16;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int LIMIT_W = 5;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(5);

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef enum logic [1:0] {
		CMD_HOLD  = 2'd0,
		CMD_INS   = 2'd1,
		CMD_EVICT = 2'd2,
		CMD_POP   = 2'd3
	} cmd_op_t;

	typedef struct packed {
		logic              valid;
		logic [PRIO_W-1:0] prio;
		logic [PAY_W-1:0]  payload;
	} entry_t;

	typedef struct packed {
		cmd_op_t           op;
		logic [PRIO_W-1:0] prio;
		logic [PAY_W-1:0]  payload;
	} cmd_t;

endpackage

// File: src/bpqel_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted chain: holds an entry, shifts toward either neighbor.
// Depends on bpqel_pkg.
module bpqel_cell
	import bpqel_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  cmd_t   cmd,
	input  entry_t left_entry,
	input  logic   left_ge,
	input  entry_t right_entry,
	output entry_t entry,
	output logic   ge
);

	logic              valid_q;
	logic [PRIO_W-1:0] prio_q;
	logic [PAY_W-1:0]  payload_q;
	entry_t            cur;
	entry_t            nxt;
	entry_t            fresh;
	logic              moves;

	assign cur   = '{valid: valid_q, prio: prio_q, payload: payload_q};
	assign fresh = '{valid: 1'b1, prio: cmd.prio, payload: cmd.payload};
	// entries at or above the new priority stay put (new one goes after them)
	assign ge    = valid_q && (prio_q >= cmd.prio);
	assign moves = !ge;

	always_comb begin
		nxt = cur;
		case (cmd.op)
			CMD_POP: begin
				nxt = right_entry;
			end
			CMD_INS: begin
				if (moves) begin
					nxt = left_ge ? fresh : left_entry;
				end
			end
			CMD_EVICT: begin
				// occupancy fixed: the last valid entry falls off the end
				if (moves && valid_q) begin
					nxt = left_ge ? fresh : left_entry;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		prio_q    <= nxt.prio;
		payload_q <= nxt.payload;
	end

	assign entry = cur;

endmodule

// File: src/bounded_priority_queue_evict_lowest_top.sv
`timescale 1ns / 1ps
// Top level of the bounded priority queue with lowest-entry eviction.
// Depends on bpqel_pkg and bpqel_cell.
//
// Entries sit in a chain of DEPTH cells kept sorted by descending priority,
// oldest first among equals; cell 0 is the next to pop and the last valid cell
// is the eviction victim. Every accepted push, eviction included, and every
// non-empty pop is one parallel shift of the chain, so one transaction is
// taken per clock and its result appears in the output register on the next
// cycle. A result waiting on m_axis_tready blocks new input only while that
// register stays full. No clearing pass is needed after reset.
module bounded_priority_queue_evict_lowest_top
	import bpqel_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [7:0] priority_req, [23:8] payload_tag
	input  logic        s_axis_tuser,  // [0] opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] accepted, [1] pop_valid, [9:2] out_priority, [25:10] out_payload,
	// [30:26] occupancy, [31] zero
	output logic [31:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [LIMIT_W-1:0] cfg_data
);

	logic [LIMIT_W-1:0] limit_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_nxt;
	logic               out_valid_q;
	logic [31:0]        out_data_q;

	entry_t             cell_entry [DEPTH];
	logic [DEPTH-1:0]   ge_vec;
	logic [DEPTH-1:0]   valid_vec;
	cmd_t               cmd;
	logic               s_accept;
	logic               evict_ok;
	logic [LIMIT_W:0]   limit_sat;
	logic               acc_bit;
	logic               popv_bit;
	logic [PRIO_W-1:0]  res_prio;
	logic [PAY_W-1:0]   res_pay;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	assign limit_sat = (limit_q > LIMIT_W'(DEPTH)) ? (LIMIT_W+1)'(DEPTH)
	                                               : {1'b0, limit_q};

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			valid_vec[i] = cell_entry[i].valid;
		end
	end

	// full queue: some held entry lies strictly below the new priority
	always_comb begin
		evict_ok = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			if (cell_entry[i].valid && (cell_entry[i].prio < s_axis_tdata[PRIO_W-1:0])) begin
				evict_ok = 1'b1;
			end
		end
	end

	always_comb begin
		cmd.prio    = s_axis_tdata[PRIO_W-1:0];
		cmd.payload = s_axis_tdata[PRIO_W+PAY_W-1:PRIO_W];
		cmd.op      = CMD_HOLD;
		count_nxt   = count_q;
		acc_bit     = 1'b0;
		popv_bit    = 1'b0;
		res_prio    = '0;
		res_pay     = '0;
		if (s_accept) begin
			if (s_axis_tuser == OP_PUSH) begin
				if ((LIMIT_W+1)'(count_q) < limit_sat) begin
					cmd.op    = CMD_INS;
					count_nxt = count_q + CNT_W'(1);
					acc_bit   = 1'b1;
				end else if (evict_ok) begin
					cmd.op  = CMD_EVICT;
					acc_bit = 1'b1;
				end
			end else if (count_q != '0) begin
				cmd.op    = CMD_POP;
				count_nxt = count_q - CNT_W'(1);
				popv_bit  = 1'b1;
				res_prio  = cell_entry[0].prio;
				res_pay   = cell_entry[0].payload;
			end
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_g;
		if (g == 0) begin : g_first
			assign left_e = '0;
			assign left_g = 1'b1;
		end else begin : g_mid
			assign left_e = cell_entry[g-1];
			assign left_g = ge_vec[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_inner
			assign right_e = cell_entry[g+1];
		end
		bpqel_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.left_entry  (left_e),
			.left_ge     (left_g),
			.right_entry (right_e),
			.entry       (cell_entry[g]),
			.ge          (ge_vec[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			count_q <= count_nxt;
			if (s_accept) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			out_data_q <= {1'b0, 5'(count_nxt), res_pay, res_prio, popv_bit, acc_bit};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(valid_vec)))
		else $error("entry count out of step with valid cells");

	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & ~(valid_vec >> 1)) == (valid_vec ^ (valid_vec >> 1)) &&
		((valid_vec & (valid_vec + DEPTH'(1))) == '0))
		else $error("valid cells not packed at head of chain");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec[0] && valid_vec[DEPTH-1]) |->
		(cell_entry[0].prio >= cell_entry[DEPTH-1].prio))
		else $error("chain not sorted by priority");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && s_axis_tuser == OP_POP && count_q != '0) |=>
		(count_q == $past(count_q) - CNT_W'(1)))
		else $error("pop did not reduce occupancy");

	a_evict_ok: assert property (@(posedge clk) disable iff (!arst_n)
		evict_ok == |(valid_vec & ~ge_vec))
		else $error("eviction decision disagrees with cell compares");
`endif

endmodule

// File: tb/tb_bounded_priority_queue_evict_lowest_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for bounded_priority_queue_evict_lowest_top: directed table, then
// random push/pop traffic under several limits, checked against an in-bench queue model.
// Depends on bpqel_pkg and the RTL under src.
module tb_bounded_priority_queue_evict_lowest_top;
	import bpqel_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PRINT_CAP   = 100;

	typedef struct packed {
		logic [CNT_W-1:0]  occupancy;
		logic [PAY_W-1:0]  payload;
		logic [PRIO_W-1:0] prio;
		logic              pop_valid;
		logic              accepted;
	} queue_result_t;

	typedef enum logic {ROW_OP, ROW_LIMIT} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic               op;
		logic [PRIO_W-1:0]  prio;
		logic [PAY_W-1:0]   tag;
		logic [LIMIT_W-1:0] limit;
		bit                 typed;
		queue_result_t      want;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [23:0]        s_axis_tdata;  // [7:0] priority_req, [23:8] payload_tag
	logic               s_axis_tuser;  // [0] opcode
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	// [0] accepted, [1] pop_valid, [9:2] out_priority, [25:10] out_payload,
	// [30:26] occupancy, [31] zero
	logic [31:0]        m_axis_tdata;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [LIMIT_W-1:0] cfg_data;

	// queue model state
	logic [PRIO_W-1:0]  held_prio [DEPTH];
	logic [PAY_W-1:0]   held_tag [DEPTH];
	bit                 held_live [DEPTH];
	int                 held_rank [DEPTH];
	int                 held_count;
	logic [LIMIT_W-1:0] limit_reg;

	queue_result_t pending_results[$];
	stim_row_t     directed_rows[$];
	int            mismatches;
	int            cycles;
	int            burst_left;
	int            stall_left;
	int            stall_mode;

	bounded_priority_queue_evict_lowest_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void retire_slot(input int s);
		held_live[s] = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			if (held_live[i] && held_rank[i] > held_rank[s])
				held_rank[i]--;
		end
		held_count--;
	endfunction

	function automatic void store_entry(input logic [PRIO_W-1:0] prio, input logic [PAY_W-1:0] tag);
		int slot;
		slot = DEPTH;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (!held_live[i])
				slot = i;
		end
		held_live[slot] = 1'b1;
		held_prio[slot] = prio;
		held_tag[slot]  = tag;
		held_rank[slot] = held_count;
		held_count++;
	endfunction

	// head: highest priority, oldest on ties; victim: lowest priority, newest on ties
	function automatic int pick_slot(input bit want_head);
		int best;
		best = DEPTH;
		for (int i = 0; i < DEPTH; i++) begin
			if (held_live[i]) begin
				if (best == DEPTH) begin
					best = i;
				end else if (want_head) begin
					if (held_prio[i] > held_prio[best] ||
					    (held_prio[i] == held_prio[best] && held_rank[i] < held_rank[best]))
						best = i;
				end else begin
					if (held_prio[i] < held_prio[best] ||
					    (held_prio[i] == held_prio[best] && held_rank[i] > held_rank[best]))
						best = i;
				end
			end
		end
		return best;
	endfunction

	function automatic queue_result_t apply_queue_op(input logic op, input logic [PRIO_W-1:0] prio,
		input logic [PAY_W-1:0] tag);
		queue_result_t r;
		int lim;
		int pick;
		r = '0;
		lim = (limit_reg > DEPTH) ? DEPTH : int'(limit_reg);
		if (op == OP_PUSH) begin
			if (held_count < lim) begin
				store_entry(prio, tag);
				r.accepted = 1'b1;
			end else begin
				pick = pick_slot(1'b0);
				if (pick < DEPTH && held_prio[pick] < prio) begin
					retire_slot(pick);
					store_entry(prio, tag);
					r.accepted = 1'b1;
				end
			end
		end else begin
			pick = pick_slot(1'b1);
			if (pick < DEPTH) begin
				r.pop_valid = 1'b1;
				r.prio      = held_prio[pick];
				r.payload   = held_tag[pick];
				retire_slot(pick);
			end
		end
		r.occupancy = CNT_W'(held_count);
		return r;
	endfunction

	task automatic flag_mismatch(input string field, input int got, input int want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("[cycle %0d] %s mismatch: got 0x%0h, want 0x%0h", cycles, field, got, want);
	endtask

	task automatic send_op(input logic op, input logic [PRIO_W-1:0] prio, input logic [PAY_W-1:0] tag,
		input bit typed, input queue_result_t want);
		queue_result_t predicted;
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = op;
		s_axis_tdata  = {tag, prio};
		do @(posedge clk); while (!s_axis_tready);
		predicted = apply_queue_op(op, prio, tag);
		pending_results = {pending_results, (typed ? want : predicted)};
	endtask

	task automatic hold_off(input int n);
		repeat (n) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
		end
	endtask

	task automatic wait_drained();
		hold_off(1);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		wait_drained();
		repeat (3) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		limit_reg = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic pace_sender();
		if (burst_left == 0) begin
			if ($urandom_range(0, 29) == 0)
				wait_drained();
			else
				hold_off($urandom_range(1, 6));
			burst_left = $urandom_range(0, 24);
		end else begin
			burst_left--;
		end
	endtask

	task automatic add_row(input row_kind_t kind, input logic op, input logic [PRIO_W-1:0] prio,
		input logic [PAY_W-1:0] tag, input bit typed, input logic acc, input logic pv,
		input logic [PRIO_W-1:0] oprio, input logic [PAY_W-1:0] otag, input int occ);
		stim_row_t row;
		row.kind  = kind;
		row.op    = op;
		row.prio  = prio;
		row.tag   = tag;
		row.limit = LIMIT_W'(prio);
		row.typed = typed;
		row.want  = '{occupancy: CNT_W'(occ), payload: otag, prio: oprio, pop_valid: pv, accepted: acc};
		directed_rows = {directed_rows, row};
	endtask

	// result checker
	always @(posedge clk) begin
		queue_result_t got;
		queue_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[30:0];
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected transaction", int'(m_axis_tdata), 0);
			end else begin
				want = pending_results.pop_front();
				if (got.accepted !== want.accepted)
					flag_mismatch("accepted", int'(got.accepted), int'(want.accepted));
				if (got.pop_valid !== want.pop_valid)
					flag_mismatch("pop_valid", int'(got.pop_valid), int'(want.pop_valid));
				if (got.prio !== want.prio)
					flag_mismatch("out_priority", int'(got.prio), int'(want.prio));
				if (got.payload !== want.payload)
					flag_mismatch("out_payload", int'(got.payload), int'(want.payload));
				if (got.occupancy !== want.occupancy)
					flag_mismatch("occupancy", int'(got.occupancy), int'(want.occupancy));
				if (m_axis_tdata[31] !== 1'b0)
					flag_mismatch("tdata[31]", int'(m_axis_tdata[31]), 0);
			end
		end
	end

	// receiver backpressure
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(8, 64);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: m_axis_tready = 1'b1;
			1: m_axis_tready = 1'($urandom_range(0, 1));
			2: m_axis_tready = (stall_left % 4 == 0);
			default: m_axis_tready = (stall_left % 8 < 2);
		endcase
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		stim_row_t     row;
		queue_result_t none;
		int            limits [9];
		int            push_pct;
		logic          op;
		logic [PRIO_W-1:0] prio;

		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_PUSH;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		mismatches    = 0;
		cycles        = 0;
		burst_left    = 0;
		stall_left    = 0;
		stall_mode    = 0;
		held_count    = 0;
		limit_reg     = LIMIT_RESET;
		none          = '0;
		for (int i = 0; i < DEPTH; i++) begin
			held_live[i] = 1'b0;
			held_prio[i] = '0;
			held_tag[i]  = '0;
			held_rank[i] = 0;
		end

		// limit is 5 out of reset
		add_row(ROW_OP, OP_POP, 8'd0, 16'h0000, 1, 0, 0, 8'd0, 16'h0000, 0);
		add_row(ROW_OP, OP_PUSH, 8'd255, 16'hFFFF, 1, 1, 0, 8'd0, 16'h0000, 1);
		add_row(ROW_OP, OP_PUSH, 8'd0, 16'h0000, 1, 1, 0, 8'd0, 16'h0000, 2);
		add_row(ROW_OP, OP_PUSH, 8'd7, 16'h1234, 1, 1, 0, 8'd0, 16'h0000, 3);
		add_row(ROW_OP, OP_PUSH, 8'd7, 16'h5678, 1, 1, 0, 8'd0, 16'h0000, 4);
		add_row(ROW_OP, OP_PUSH, 8'd7, 16'h9ABC, 1, 1, 0, 8'd0, 16'h0000, 5);
		add_row(ROW_OP, OP_PUSH, 8'd0, 16'hAAAA, 1, 0, 0, 8'd0, 16'h0000, 5);
		add_row(ROW_OP, OP_PUSH, 8'd1, 16'h5555, 1, 1, 0, 8'd0, 16'h0000, 5);
		add_row(ROW_OP, OP_PUSH, 8'd7, 16'hDDDD, 0, 0, 0, 8'd0, 16'h0000, 0);
		add_row(ROW_OP, OP_PUSH, 8'd7, 16'hEEEE, 0, 0, 0, 8'd0, 16'h0000, 0);
		// limit below occupancy
		add_row(ROW_LIMIT, OP_PUSH, 8'd2, 16'h0000, 0, 0, 0, 8'd0, 16'h0000, 0);
		add_row(ROW_OP, OP_PUSH, 8'd3, 16'h3333, 0, 0, 0, 8'd0, 16'h0000, 0);
		add_row(ROW_OP, OP_PUSH, 8'd200, 16'h0F0F, 0, 0, 0, 8'd0, 16'h0000, 0);
		add_row(ROW_OP, OP_POP, 8'd0, 16'h0000, 0, 0, 0, 8'd0, 16'h0000, 0);
		add_row(ROW_OP, OP_POP, 8'd0, 16'h0000, 0, 0, 0, 8'd0, 16'h0000, 0);
		add_row(ROW_OP, OP_POP, 8'd0, 16'h0000, 0, 0, 0, 8'd0, 16'h0000, 0);
		add_row(ROW_OP, OP_POP, 8'd0, 16'h0000, 0, 0, 0, 8'd0, 16'h0000, 0);
		// zero limit: only replacement is possible
		add_row(ROW_LIMIT, OP_PUSH, 8'd0, 16'h0000, 0, 0, 0, 8'd0, 16'h0000, 0);
		add_row(ROW_OP, OP_PUSH, 8'd255, 16'hF0F0, 0, 0, 0, 8'd0, 16'h0000, 0);
		add_row(ROW_OP, OP_POP, 8'd0, 16'h0000, 0, 0, 0, 8'd0, 16'h0000, 0);
		add_row(ROW_OP, OP_POP, 8'd0, 16'h0000, 1, 0, 0, 8'd0, 16'h0000, 0);
		add_row(ROW_OP, OP_PUSH, 8'd255, 16'hFFFF, 1, 0, 0, 8'd0, 16'h0000, 0);
		add_row(ROW_OP, OP_POP, 8'd0, 16'h0000, 1, 0, 0, 8'd0, 16'h0000, 0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_LIMIT) begin
				write_limit(row.limit);
			end else begin
				send_op(row.op, row.prio, row.tag, row.typed, row.want);
				pace_sender();
			end
		end

		limits = '{16, 31, 1, 0, 4, 16, $urandom_range(1, 15), 2, 5};
		foreach (limits[p]) begin
			write_limit(LIMIT_W'(limits[p]));
			push_pct = 85;
			for (int n = 0; n < 56; n++) begin
				if (n % 14 == 0) begin
					case ($urandom_range(0, 2))
						0: push_pct = 85;
						1: push_pct = 50;
						default: push_pct = 20;
					endcase
				end
				op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
				case ($urandom_range(0, 3))
					0: prio = PRIO_W'($urandom_range(0, 3));
					1: prio = PRIO_W'($urandom_range(0, 255));
					2: prio = $urandom_range(0, 1) ? 8'd255 : 8'd0;
					default: prio = PRIO_W'($urandom_range(120, 135));
				endcase
				send_op(op, prio, PAY_W'($urandom), 0, none);
				pace_sender();
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
